@@ rtl/fifo_process_scheduler_defines.svh @@
// Assertion macros for the process scheduler checker.
// Used by the checker file only; depends on nothing.
`ifndef FIFO_PROCESS_SCHEDULER_DEFINES_SVH
`define FIFO_PROCESS_SCHEDULER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FPS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error("fps check failed");
// Next-cycle implication.
`define FPS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error("fps check failed");
`endif

@@ rtl/fps_pkg.sv @@
// Package for the process scheduler: sizes, state codes, request codes.
// No dependencies.
package fps_pkg;
	localparam int MAX_ENTRIES_D = 16;
	localparam int BURST_BITS_D  = 4;
	localparam int SLEEP_BITS_D  = 3;
	localparam int TIME_BITS_D   = 16;
	localparam int CNT_W         = 5;
	localparam logic [CNT_W-1:0] PROC_COUNT_RST = 5'd10;
	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_SLEEP = 2'd3;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	localparam logic [1:0] REQ_REPORT = 2'd3;
endpackage

@@ rtl/fps_table.sv @@
// Process table: per-entry registers with one shared update unit applied to
// the entry the sequencer selects. Depends on fps_pkg.
module fps_table #(
	parameter int MAX_ENTRIES = fps_pkg::MAX_ENTRIES_D,
	parameter int BURST_BITS  = fps_pkg::BURST_BITS_D,
	parameter int SLEEP_BITS  = fps_pkg::SLEEP_BITS_D,
	parameter int TIME_BITS   = fps_pkg::TIME_BITS_D,
	localparam int IW = $clog2(MAX_ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IW-1:0]         sel,
	// operation strobes
	input  logic                  do_load,
	input  logic                  do_age,     // wait++ / sleep countdown
	input  logic                  do_run,     // burst step of running entry
	input  logic                  do_set_run,
	input  logic                  fin,
	input  logic [BURST_BITS-1:0] burst_in,
	input  logic [SLEEP_BITS-1:0] sleep_in,
	input  logic [BURST_BITS-1:0] nburst_in,
	input  logic [TIME_BITS-1:0]  now,
	output logic [1:0]            st_o,
	output logic [TIME_BITS-1:0]  rstamp_o,
	output logic [TIME_BITS-1:0]  wait_o,
	output logic [TIME_BITS-1:0]  ta_o,
	output logic                  burst_end_o
);
	logic [1:0]            st_q     [MAX_ENTRIES];
	logic [BURST_BITS-1:0] burst_q  [MAX_ENTRIES];
	logic [SLEEP_BITS-1:0] sleep_q  [MAX_ENTRIES];
	logic [TIME_BITS-1:0]  wait_q   [MAX_ENTRIES];
	logic [TIME_BITS-1:0]  rstamp_q [MAX_ENTRIES];
	logic [TIME_BITS-1:0]  arr_q    [MAX_ENTRIES];
	logic [TIME_BITS-1:0]  fin_q    [MAX_ENTRIES];
	logic                  hf_q     [MAX_ENTRIES];

	assign st_o        = st_q[sel];
	assign rstamp_o    = rstamp_q[sel];
	assign wait_o      = wait_q[sel];
	assign burst_end_o = burst_q[sel] <= BURST_BITS'(1);
	assign ta_o = (st_q[sel] == fps_pkg::ST_DONE && hf_q[sel] && fin_q[sel] >= arr_q[sel])
		? fin_q[sel] - arr_q[sel] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				st_q[i] <= fps_pkg::ST_DONE; burst_q[i] <= '0; sleep_q[i] <= '0;
				wait_q[i] <= '0; rstamp_q[i] <= '0; arr_q[i] <= '0;
				fin_q[i] <= '0; hf_q[i] <= 1'b0;
			end
		end else if (do_load) begin
			burst_q[sel] <= burst_in; sleep_q[sel] <= '0; st_q[sel] <= fps_pkg::ST_READY;
			wait_q[sel] <= '0; arr_q[sel] <= now; rstamp_q[sel] <= now;
			fin_q[sel] <= '0; hf_q[sel] <= 1'b0;
		end else if (do_age) begin
			if (st_q[sel] == fps_pkg::ST_READY && wait_q[sel] != '1)
				wait_q[sel] <= wait_q[sel] + TIME_BITS'(1);
			else if (st_q[sel] == fps_pkg::ST_SLEEP) begin
				if (sleep_q[sel] <= SLEEP_BITS'(1)) begin
					sleep_q[sel] <= '0; st_q[sel] <= fps_pkg::ST_READY;
					rstamp_q[sel] <= now;
				end else
					sleep_q[sel] <= sleep_q[sel] - SLEEP_BITS'(1);
			end
		end else if (do_run) begin
			if (burst_q[sel] <= BURST_BITS'(1)) begin
				if (fin) begin
					burst_q[sel] <= '0; st_q[sel] <= fps_pkg::ST_DONE;
					fin_q[sel] <= now; hf_q[sel] <= 1'b1;
				end else begin
					sleep_q[sel] <= sleep_in; burst_q[sel] <= nburst_in;
					st_q[sel] <= fps_pkg::ST_SLEEP;
				end
			end else
				burst_q[sel] <= burst_q[sel] - BURST_BITS'(1);
		end else if (do_set_run) begin
			st_q[sel] <= fps_pkg::ST_RUN;
		end
	end
endmodule

@@ rtl/fifo_process_scheduler.sv @@
// Non-preemptive first-come process scheduler, iterative over the table.
// Per item (N entries in use): a load is written in the idle state after its beat; a start
// dispatches via SCAN and SETR when nothing runs; a tick goes AGE, RUN, then SCAN and SETR
// if a burst ended or nothing ran, then N result beats; a report gives N beats. One item at
// a time; the single table port sets the rate. Reset (arst_n low, asynchronous): table
// empty, nothing running, time zero, proc_count 10. Depends on fps_pkg and fps_table.
module fifo_process_scheduler #(
	parameter int MAX_ENTRIES = fps_pkg::MAX_ENTRIES_D,
	parameter int BURST_BITS  = fps_pkg::BURST_BITS_D,
	parameter int SLEEP_BITS  = fps_pkg::SLEEP_BITS_D,
	parameter int TIME_BITS   = fps_pkg::TIME_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  proc_index,
	input  logic [3:0]  burst_value,
	input  logic        finish_now,
	input  logic [2:0]  io_time,
	input  logic [3:0]  next_burst,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  entry_index,
	output logic [1:0]  entry_state,
	output logic [15:0] entry_wait,
	output logic [15:0] entry_turnaround,
	output logic [15:0] time_now,
	output logic [4:0]  done_count,
	output logic        all_done,
	output logic        last_result
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int RW = $clog2(MAX_ENTRIES + 1);

	localparam logic [2:0] S_IDLE = 3'd0, S_AGE = 3'd1, S_RUN = 3'd2,
		S_SCAN = 3'd3, S_SETR = 3'd4, S_OUT = 3'd5;

	// APB: only proc_count; pready always high
	logic [4:0] pcount_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {27'd0, pcount_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pcount_q <= fps_pkg::PROC_COUNT_RST;
		else if (psel && penable && pwrite && paddr == 2'd0) pcount_q <= pwdata[4:0];
	end
	// entries in use, capped at table depth
	logic [RW-1:0] n_use;
	assign n_use = (32'(pcount_q) < MAX_ENTRIES) ? RW'(pcount_q) : RW'(MAX_ENTRIES);

	logic [2:0]  state_q;
	logic [RW-1:0] idx_q;
	logic [RW-1:0] run_q, best_q, ran_q;
	logic [TIME_BITS-1:0] tick_q, bstamp_q;
	logic [4:0]  fcnt_q;
	logic        rep_q, fin_q;
	logic [BURST_BITS-1:0] nb_q;
	logic [SLEEP_BITS-1:0] sl_q;
	logic [BURST_BITS-1:0] ld_q;
	logic [IW-1:0] ldi_q;
	// remember whether the item is a tick, so dispatch after a tick reports
	logic req_is_tick_q;

	logic [IW-1:0] sel;
	logic [1:0] t_st;
	logic [TIME_BITS-1:0] t_rs, t_wt, t_ta;
	logic t_bend;
	logic do_age, do_run, do_setr;
	logic acc;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		sel = idx_q[IW-1:0];
		if (state_q == S_RUN) sel = run_q[IW-1:0];
		else if (state_q == S_SETR) sel = best_q[IW-1:0];
		else if (state_q == S_IDLE) sel = ldi_q;
	end
	// a load is written into the table in the idle cycle after its beat
	logic ld_pend_q;
	assign do_age  = (state_q == S_AGE);
	assign do_run  = (state_q == S_RUN) && run_q < RW'(MAX_ENTRIES) && t_st == fps_pkg::ST_RUN;
	assign do_setr = (state_q == S_SETR) && best_q < RW'(MAX_ENTRIES);

	fps_table #(.MAX_ENTRIES(MAX_ENTRIES), .BURST_BITS(BURST_BITS),
		.SLEEP_BITS(SLEEP_BITS), .TIME_BITS(TIME_BITS)) u_tab (
		.clk(clk), .arst_n(arst_n), .sel(sel),
		.do_load(ld_pend_q && state_q == S_IDLE), .do_age(do_age), .do_run(do_run),
		.do_set_run(do_setr), .fin(fin_q), .burst_in(ld_q), .sleep_in(sl_q),
		.nburst_in(nb_q), .now(tick_q), .st_o(t_st), .rstamp_o(t_rs),
		.wait_o(t_wt), .ta_o(t_ta), .burst_end_o(t_bend));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0; run_q <= RW'(MAX_ENTRIES);
			best_q <= RW'(MAX_ENTRIES); ran_q <= RW'(MAX_ENTRIES); tick_q <= '0;
			fcnt_q <= '0; rep_q <= 1'b0; fin_q <= 1'b0; ld_pend_q <= 1'b0;
			nb_q <= '0; sl_q <= '0; ld_q <= '0; ldi_q <= '0; bstamp_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					ld_pend_q <= 1'b0;
					if (acc) begin
						fin_q <= finish_now;
						sl_q <= SLEEP_BITS'(io_time);
						nb_q <= BURST_BITS'(next_burst);
						idx_q <= '0; best_q <= RW'(MAX_ENTRIES);
						case (req_type)
							fps_pkg::REQ_LOAD: begin
								if (RW'(proc_index) < n_use) begin
									ld_pend_q <= 1'b1; ldi_q <= IW'(proc_index);
									ld_q <= BURST_BITS'(burst_value);
									if (run_q == RW'(proc_index)) run_q <= RW'(MAX_ENTRIES);
								end
							end
							fps_pkg::REQ_START:
								if (run_q >= RW'(MAX_ENTRIES)) state_q <= S_SCAN;
							fps_pkg::REQ_TICK: begin
								if (tick_q != '1) tick_q <= tick_q + TIME_BITS'(1);
								ran_q <= RW'(MAX_ENTRIES);
								state_q <= (n_use == '0) ? S_RUN : S_AGE;
							end
							default: begin
								rep_q <= 1'b1;
								if (n_use != '0) state_q <= S_OUT;
							end
						endcase
					end
				end
				S_AGE: begin
					// advance one entry per cycle
					if (idx_q + RW'(1) >= n_use) state_q <= S_RUN;
					idx_q <= idx_q + RW'(1);
				end
				S_RUN: begin
					idx_q <= '0;
					rep_q <= 1'b0;
					if (run_q < RW'(MAX_ENTRIES) && t_st == fps_pkg::ST_RUN) begin
						ran_q <= run_q;
						if (t_bend) begin
							if (fin_q && fcnt_q != fps_pkg::COUNT_MAX)
								fcnt_q <= fcnt_q + 5'd1;
							state_q <= S_SCAN;
						end else state_q <= (n_use == '0) ? S_IDLE : S_OUT;
					end else state_q <= S_SCAN;
				end
				S_SCAN: begin
					// earliest-ready search, one entry per cycle
					if (idx_q >= n_use) begin
						state_q <= S_SETR;
					end else begin
						if (t_st == fps_pkg::ST_READY &&
							(best_q == RW'(MAX_ENTRIES) || t_rs < bstamp_q)) begin
							best_q <= idx_q; bstamp_q <= t_rs;
						end
						idx_q <= idx_q + RW'(1);
					end
				end
				S_SETR: begin
					run_q <= best_q; idx_q <= '0;
					state_q <= (req_is_tick_q && n_use != '0) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (idx_q + RW'(1) >= n_use) state_q <= S_IDLE;
						idx_q <= idx_q + RW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_is_tick_q <= 1'b0;
		else if (acc) req_is_tick_q <= (req_type == fps_pkg::REQ_TICK);
	end

	// result beat straight off the selected entry
	assign out_valid = (state_q == S_OUT);
	assign entry_index = 4'(idx_q);
	assign entry_state = (!rep_q && idx_q == ran_q) ? fps_pkg::ST_RUN : t_st;
	assign entry_wait = rep_q ? 16'(t_wt) : 16'd0;
	assign entry_turnaround = rep_q ? 16'(t_ta) : 16'd0;
	assign time_now = 16'(tick_q);
	assign done_count = fcnt_q;
	assign all_done = 32'(fcnt_q) >= 32'(n_use);
	assign last_result = (idx_q + RW'(1) == n_use);
endmodule

@@ rtl/fps_checker.sv @@
// Port-level checker for the process scheduler, bound to the top level.
// Depends on fifo_process_scheduler_defines.svh.
`include "fifo_process_scheduler_defines.svh"
module fps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] entry_state,
	input logic [15:0] time_now,
	input logic       last_result
);
	// hold a stalled result
	`FPS_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(time_now) && $stable(entry_state) && $stable(last_result))
	// hold a stalled input beat
	`FPS_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid)
	// never take an item while a result beat is on offer
	`FPS_ASSERT_IMP(a_busy, clk, arst_n, out_valid, in_stall)
	// time never goes backwards
	`FPS_ASSERT_NXT(a_time, clk, arst_n, 1'b1, time_now >= $past(time_now))
endmodule

bind fifo_process_scheduler fps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .entry_state(entry_state),
	.time_now(time_now), .last_result(last_result));

@@ test/fifo_process_scheduler_tb.sv @@
// Self-checking bench for fifo_process_scheduler: a behavioural scheduler model
// predicts every result beat, which is checked field by field. Depends on fps_pkg.
`timescale 1ns / 100ps

module fifo_process_scheduler_tb;

	localparam int NENT = 16;
	localparam logic [15:0] TMAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] req;
		logic [3:0] idx;
		logic [3:0] burst;
		logic       fin;
		logic [2:0] io;
		logic [3:0] nburst;
	} sched_req_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [1:0]  st;
		logic [15:0] wt;
		logic [15:0] ta;
		logic [15:0] tnow;
		logic [4:0]  dcnt;
		logic        alld;
		logic        last;
	} entry_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	sched_req_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	entry_beat_t got;

	fifo_process_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(cur.req), .proc_index(cur.idx), .burst_value(cur.burst),
		.finish_now(cur.fin), .io_time(cur.io), .next_burst(cur.nburst),
		.out_valid(out_valid), .out_stall(out_stall),
		.entry_index(got.idx), .entry_state(got.st), .entry_wait(got.wt),
		.entry_turnaround(got.ta), .time_now(got.tnow), .done_count(got.dcnt),
		.all_done(got.alld), .last_result(got.last)
	);

	// Scheduler shadow state
	logic [4:0]  m_count;
	logic [1:0]  m_state   [NENT];
	logic [3:0]  m_burst   [NENT];
	logic [2:0]  m_sleep   [NENT];
	logic [15:0] m_wait    [NENT];
	logic [15:0] m_rdy     [NENT];
	logic [15:0] m_arr     [NENT];
	logic [15:0] m_fin     [NENT];
	logic        m_done    [NENT];
	int          m_running;
	logic [15:0] m_ticks;
	logic [4:0]  m_finished;

	sched_req_t  pending_reqs[$];
	entry_beat_t expected_beats[$];
	int          errors = 0;
	bit          calm = 1'b0;
	bit          drive_done = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int entries_in_use();
		return (m_count < NENT) ? int'(m_count) : NENT;
	endfunction

	function automatic void sched_reset();
		for (int i = 0; i < NENT; i++) begin
			m_state[i] = fps_pkg::ST_DONE; m_burst[i] = '0; m_sleep[i] = '0; m_wait[i] = '0;
			m_rdy[i] = '0; m_arr[i] = '0; m_fin[i] = '0; m_done[i] = 1'b0;
		end
		m_running = NENT; m_ticks = '0; m_finished = '0; m_count = fps_pkg::PROC_COUNT_RST;
	endfunction

	// Pick the earliest-ready entry, lowest index on a tie.
	function automatic void pick_next();
		int n;
		int best;
		n = entries_in_use();
		best = NENT;
		for (int i = 0; i < n; i++)
			if (m_state[i] == fps_pkg::ST_READY && (best == NENT || m_rdy[i] < m_rdy[best]))
				best = i;
		m_running = best;
		if (best < NENT) m_state[best] = fps_pkg::ST_RUN;
	endfunction

	function automatic void push_beat(int i, logic [1:0] st, logic [15:0] w,
			logic [15:0] t, int n);
		entry_beat_t b;
		b.idx = i[3:0]; b.st = st; b.wt = w; b.ta = t; b.tnow = m_ticks;
		b.dcnt = m_finished; b.alld = (int'(m_finished) >= n);
		b.last = (i + 1 == n);
		expected_beats.push_back(b);
	endfunction

	function automatic void sched_apply(sched_req_t r);
		int n;
		int ran;
		int c;
		logic [15:0] t;
		n = entries_in_use();
		ran = NENT;
		case (r.req)
			fps_pkg::REQ_LOAD: begin
				if (int'(r.idx) < n) begin
					m_burst[r.idx] = r.burst; m_sleep[r.idx] = '0;
					m_state[r.idx] = fps_pkg::ST_READY; m_wait[r.idx] = '0;
					m_arr[r.idx] = m_ticks; m_rdy[r.idx] = m_ticks;
					m_fin[r.idx] = '0; m_done[r.idx] = 1'b0;
					if (m_running == int'(r.idx)) m_running = NENT;
				end
			end
			fps_pkg::REQ_START: begin
				if (m_running >= NENT) pick_next();
			end
			fps_pkg::REQ_TICK: begin
				if (m_ticks != TMAX) m_ticks++;
				for (int i = 0; i < n; i++)
					if (m_state[i] == fps_pkg::ST_READY && m_wait[i] != TMAX) m_wait[i]++;
				for (int i = 0; i < n; i++)
					if (m_state[i] == fps_pkg::ST_SLEEP) begin
						if (m_sleep[i] <= 1) begin
							m_sleep[i] = '0; m_state[i] = fps_pkg::ST_READY;
							m_rdy[i] = m_ticks;
						end else m_sleep[i]--;
					end
				if (m_running < NENT && m_state[m_running] == fps_pkg::ST_RUN) begin
					c = m_running;
					ran = c;
					if (m_burst[c] <= 1) begin
						if (r.fin) begin
							m_burst[c] = '0; m_state[c] = fps_pkg::ST_DONE; m_fin[c] = m_ticks;
							m_done[c] = 1'b1;
							if (m_finished != fps_pkg::COUNT_MAX) m_finished++;
						end else begin
							m_sleep[c] = r.io; m_burst[c] = r.nburst;
							m_state[c] = fps_pkg::ST_SLEEP;
						end
						pick_next();
					end else m_burst[c]--;
				end else pick_next();
				for (int i = 0; i < n; i++)
					push_beat(i, (i == ran) ? fps_pkg::ST_RUN : m_state[i], '0, '0, n);
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					t = '0;
					if (m_state[i] == fps_pkg::ST_DONE && m_done[i] && m_fin[i] >= m_arr[i])
						t = m_fin[i] - m_arr[i];
					push_beat(i, m_state[i], m_wait[i], t, n);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int got_v, int exp_v);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
		errors++;
	endtask

	// Driver: present the next beat, hold it while stalled, idle in bursts.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sched_apply(cur);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_gap <= $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !drive_done) begin
					cur <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result beat against the oldest prediction.
	int out_gap = 0;
	always @(posedge clk) begin
		entry_beat_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat, index", got.idx, -1);
				end else begin
					e = expected_beats.pop_front();
					if (got.idx !== e.idx) report_mismatch("entry_index", got.idx, e.idx);
					if (got.st !== e.st) report_mismatch("entry_state", got.st, e.st);
					if (got.wt !== e.wt) report_mismatch("entry_wait", got.wt, e.wt);
					if (got.ta !== e.ta) report_mismatch("entry_turnaround", got.ta, e.ta);
					if (got.tnow !== e.tnow) report_mismatch("time_now", got.tnow, e.tnow);
					if (got.dcnt !== e.dcnt) report_mismatch("done_count", got.dcnt, e.dcnt);
					if (got.alld !== e.alld) report_mismatch("all_done", got.alld, e.alld);
					if (got.last !== e.last) report_mismatch("last_result", got.last, e.last);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic sched_req_t make_req(int rq, int ix, int bu, int fi, int io, int nb);
		sched_req_t r;
		r.req = 2'(rq); r.idx = 4'(ix); r.burst = 4'(bu); r.fin = 1'(fi);
		r.io = 3'(io); r.nburst = 4'(nb);
		return r;
	endfunction

	function automatic sched_req_t rand_tick();
		return make_req(fps_pkg::REQ_TICK, $urandom, $urandom, $urandom_range(0, 2) == 0,
			$urandom, $urandom);
	endfunction

	// Queue a workload: load entries, start, then mixed ticks, loads, starts and reports, then a report.
	function automatic void queue_workload(int n, int ticks);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 3) != 0)
				pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, i, $urandom, $urandom,
					$urandom, $urandom));
		pending_reqs.push_back(make_req(fps_pkg::REQ_START, $urandom, $urandom, 0, 0, 0));
		for (int t = 0; t < ticks; t++) begin
			case ($urandom_range(0, 19))
				0: pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, $urandom, $urandom,
					0, 0, 0));
				1: pending_reqs.push_back(make_req(fps_pkg::REQ_START, $urandom, $urandom,
					0, 0, 0));
				2: pending_reqs.push_back(make_req(fps_pkg::REQ_REPORT, $urandom, $urandom,
					0, 0, 0));
				default: pending_reqs.push_back(rand_tick());
			endcase
		end
		pending_reqs.push_back(make_req(fps_pkg::REQ_REPORT, $urandom, $urandom, 0, 0, 0));
	endfunction

	// Hold until all queued beats are accepted and all results have come back.
	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic apb_write(logic [4:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {27'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		m_count = v;
	endtask

	initial begin
		int counts[5];
		sched_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default size, extremes, ignored loads, start while running.
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 0, 15, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 15, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 9, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 3, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_START, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_START, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 0, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 0, 7, 15));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 15, 15, 1, 7, 15));
		pending_reqs.push_back(make_req(fps_pkg::REQ_REPORT, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_REPORT, 0, 0, 0, 0, 0));
		drain();

		// Sizes: zero entries, one, full table, the widest encoding, then a mix.
		apb_write(5'd0);
		pending_reqs.push_back(make_req(fps_pkg::REQ_LOAD, 0, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(fps_pkg::REQ_REPORT, 0, 0, 0, 0, 0));
		drain();

		counts = '{1, 16, 31, 5, 8};
		foreach (counts[k]) begin
			apb_write(counts[k][4:0]);
			queue_workload(counts[k] > 16 ? 16 : counts[k], 12);
			drain();
		end

		// Random phases; the last one runs without idling.
		for (int ph = 0; ph < 4; ph++) begin
			apb_write(5'($urandom_range(1, 16)));
			if (ph == 3) calm = 1'b1;
			queue_workload(entries_in_use(), 16);
			drain();
		end

		drive_done = 1'b1;
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
